FILE: rtl/slid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slid_pkg
// Shared constants, codes and handshake types for the sorted list block.
// ----------------------------------------------------------------------------
package slid_pkg;

    localparam int CAPACITY = 8;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 4;
    localparam int STATUS_W = 2;

    // operation kinds
    localparam logic KIND_ADD = 1'b0;
    localparam logic KIND_DEL = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic load;    // capture the incoming item
        logic do_add;  // insert the held value in order
        logic do_del;  // remove the first matching entry
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic op_del;  // held item is a delete
        logic full;
        logic empty;
        logic found;   // held value matches a stored entry
    } t_flags;

endpackage
`default_nettype wire

FILE: rtl/slid_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slid_ctrl
// Two-state sequencer: capture an item, then execute it and report status.
// ----------------------------------------------------------------------------
module slid_ctrl (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire slid_pkg::t_flags            i_flags,
    output slid_pkg::t_cmd                   o_cmd,
    output logic                             o_done,
    output logic [slid_pkg::STATUS_W-1:0]    o_status
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                          r_state, n_state;
    logic                          r_done, n_done;
    logic [slid_pkg::STATUS_W-1:0] r_status, n_status;

    always_comb begin
        n_state     = r_state;
        n_done      = 1'b0;
        n_status    = r_status;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                priority if (i_flags.op_del) begin
                    priority if (i_flags.empty) begin
                        n_status = slid_pkg::ST_EMPTY;
                    end else if (i_flags.found) begin
                        n_status     = slid_pkg::ST_OK;
                        o_cmd.do_del = 1'b1;
                    end else begin
                        n_status = slid_pkg::ST_MISSING;
                    end
                end else if (i_flags.full) begin
                    n_status = slid_pkg::ST_FULL;
                end else begin
                    n_status     = slid_pkg::ST_OK;
                    o_cmd.do_add = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_status <= n_status;
    end

    assign busy     = (r_state == S_EXEC);
    assign o_done   = r_done;
    assign o_status = r_status;

endmodule
`default_nettype wire

FILE: rtl/slid_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slid_dp
// Compare-and-shift register array holding the sorted entries and fill count.
// ----------------------------------------------------------------------------
module slid_dp (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire slid_pkg::t_cmd                   i_cmd,
    input  wire                                   i_kind,
    input  wire  [slid_pkg::VAL_W-1:0]            i_value,
    output slid_pkg::t_flags                      o_flags,
    output logic [slid_pkg::CNT_W-1:0]            o_fill,
    output logic [slid_pkg::VAL_W-1:0]            o_smallest,
    output logic [slid_pkg::VAL_W-1:0]            o_largest
);

    logic                         r_kind;
    logic [slid_pkg::VAL_W-1:0]   r_value;
    logic [slid_pkg::VAL_W-1:0]   r_entries [slid_pkg::CAPACITY];
    logic [slid_pkg::CNT_W-1:0]   r_fill, n_fill;

    logic [slid_pkg::CAPACITY-1:0] le;    // stored entry <= held value
    logic [slid_pkg::CAPACITY-1:0] seen;  // a match at this place or before
    logic [slid_pkg::VAL_W-1:0]    ins_e [slid_pkg::CAPACITY];
    logic [slid_pkg::VAL_W-1:0]    del_e [slid_pkg::CAPACITY];
    logic [slid_pkg::IDX_W-1:0]    last_idx;

    // per-cell compares; le is a prefix because the list is sorted
    always_comb begin
        for (int k = 0; k < slid_pkg::CAPACITY; k++) begin
            le[k] = (slid_pkg::CNT_W'(k) < r_fill) &&
                    ($signed(r_entries[k]) <= $signed(r_value));
            if (k == 0) begin
                seen[k] = (r_fill != '0) && (r_entries[k] == r_value);
            end else begin
                seen[k] = seen[k-1] ||
                          ((slid_pkg::CNT_W'(k) < r_fill) && (r_entries[k] == r_value));
            end
        end
    end

    // shifted copies: insert opens a slot, delete closes the gap
    always_comb begin
        for (int k = 0; k < slid_pkg::CAPACITY; k++) begin
            if (le[k]) begin
                ins_e[k] = r_entries[k];
            end else if (k == 0) begin
                ins_e[k] = r_value;
            end else if (le[k-1]) begin
                ins_e[k] = r_value;
            end else begin
                ins_e[k] = r_entries[k-1];
            end
            if (k < slid_pkg::CAPACITY - 1 && seen[k]) begin
                del_e[k] = r_entries[k+1];
            end else begin
                del_e[k] = r_entries[k];
            end
        end
    end

    always_comb begin
        n_fill = r_fill;
        if (i_cmd.do_add) begin
            n_fill = r_fill + slid_pkg::CNT_W'(1);
        end else if (i_cmd.do_del) begin
            n_fill = r_fill - slid_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
        for (int k = 0; k < slid_pkg::CAPACITY; k++) begin
            if (i_cmd.do_add) begin
                r_entries[k] <= ins_e[k];
            end else if (i_cmd.do_del) begin
                r_entries[k] <= del_e[k];
            end
        end
    end

    assign last_idx      = slid_pkg::IDX_W'(r_fill - slid_pkg::CNT_W'(1));
    assign o_fill        = r_fill;
    assign o_smallest    = (r_fill == '0) ? '0 : r_entries[0];
    assign o_largest     = (r_fill == '0) ? '0 : r_entries[last_idx];
    assign o_flags.op_del = (r_kind == slid_pkg::KIND_DEL);
    assign o_flags.full  = (r_fill == slid_pkg::CNT_W'(slid_pkg::CAPACITY));
    assign o_flags.empty = (r_fill == '0);
    assign o_flags.found = seen[slid_pkg::CAPACITY-1];

endmodule
`default_nettype wire

FILE: rtl/sorted_list_insert_delete.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Bounded ascending list of signed values with add and delete commands.
// ----------------------------------------------------------------------------
// An accepted item is captured, then executed in the execute state; its
// result is on the outputs with o_done high once that state has been left.
// No new item is taken while busy, which is high for the single execute
// cycle, in which the whole register array compares and shifts at once.
// Reset (i_rst_n low at a rising edge) empties the list and clears busy and
// o_done; stored values are not cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                start,
    output logic                               busy,
    input  wire                                i_kind,
    input  wire  signed [slid_pkg::VAL_W-1:0]  i_value,
    output logic                               o_done,
    output logic [slid_pkg::STATUS_W-1:0]      o_status,
    output logic [slid_pkg::COUNT_W-1:0]       o_count,
    output logic signed [slid_pkg::VAL_W-1:0]  o_smallest,
    output logic signed [slid_pkg::VAL_W-1:0]  o_largest
);

    slid_pkg::t_cmd             cmd;
    slid_pkg::t_flags           flags;
    logic [slid_pkg::CNT_W-1:0] fill;
    logic [slid_pkg::VAL_W-1:0] smallest;
    logic [slid_pkg::VAL_W-1:0] largest;

    // sequencer: capture, execute, report
    slid_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_flags  (flags),
        .o_cmd    (cmd),
        .o_done   (o_done),
        .o_status (o_status)
    );

    // entry array; min and max read straight from the ends of the list,
    // which hold still through the result cycle
    slid_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_kind     (i_kind),
        .i_value    (i_value),
        .o_flags    (flags),
        .o_fill     (fill),
        .o_smallest (smallest),
        .o_largest  (largest)
    );

    // count carries the full fill level
    assign o_count    = slid_pkg::COUNT_W'(fill);
    assign o_smallest = smallest;
    assign o_largest  = largest;

`ifndef NO_ASSERTIONS
    // an accepted item is executed in the very next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not enter execute");

    // every execute cycle is followed by exactly one result strobe
    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_done && !busy))
        else $error("execute cycle not followed by a result");

    // a result never appears without an item having executed
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a preceding execute");

    // a successful delete drops the fill by one
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && cmd.do_del) |=> (fill == $past(fill) - slid_pkg::CNT_W'(1)))
        else $error("delete did not reduce the fill level");
`endif

endmodule
`default_nettype wire
